// ----- sv/hnt_pkg.sv -----
// Package for the heightmap normal/tangent core.
// Holds register indexes, field widths and the pipeline control type.
package hnt_pkg;

  localparam int unsigned HeightW = 16;
  localparam int unsigned GainW   = 24;
  localparam int unsigned GridW   = 11;
  localparam int unsigned CompW   = 16;
  localparam int unsigned CfgAddrW = 1;

  localparam logic [CfgAddrW-1:0] RegGridWidth  = 1'd0;
  localparam logic [CfgAddrW-1:0] RegHeightGain = 1'd1;

  // Difference times gain: 17-bit signed by 24-bit unsigned.
  localparam int unsigned DiffW = 42;

  // Pipeline side information for one vertex.
  typedef struct packed {
    logic vld;
    logic border;
  } vtx_ctl_t;

endpackage

// ----- sv/heightmap_normal_tangent_core.sv -----
// Top level of the heightmap normal/tangent core: line buffer, counters,
// difference stage and two unit-vector pipelines. Depends on hnt_pkg, hnt_unit3.
//
//  Port group   Direction  Beat content
//  s_axis_*     in         tdata: height_sample[15:0]; tuser: frame_start
//  m_axis_*     out        tdata: normal_x, normal_y, normal_z, tangent_y, tangent_z
//                          (16 bits each, from bit 0 up); tuser: on_border
//  cfg_*        in         plain register writes, no read-back
//
// One sample per cycle is accepted while the output is not stalled; the pipeline depth is
// set by the bit-serial square root and divider stages of the unit-vector pipelines.
// The whole pipeline advances only when the output register is free or taken,
// so a stall on m_axis_tready freezes every stage including the line buffer read.
// Reset clears counters and valid bits; the line buffer needs no clearing.
module heightmap_normal_tangent_core #(
  parameter int unsigned MaxWidth = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hnt_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [hnt_pkg::GainW-1:0]    cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,  // height_sample
  input  logic                         s_axis_tuser,  // frame_start
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [79:0]                  m_axis_tdata,  // nx, ny, nz, ty, tz
  output logic                         m_axis_tuser   // on_border
);
  import hnt_pkg::*;

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned CntW = ColW + 1;
  localparam int unsigned UnitLat = 1 + 1 + 1 + 1 + 31 + 1 + 16 + 1;
  localparam int unsigned LatW = UnitLat;

  // Configuration registers.
  logic [GridW-1:0] grid_width_q;
  logic [GainW-1:0] gain_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= GridW'(1024);
      gain_q       <= GainW'(500);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegGridWidth:  grid_width_q <= cfg_wdata_i[GridW-1:0];
        RegHeightGain: gain_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Global advance: the output register is empty or being drained.
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  logic acc;
  assign acc = s_axis_tvalid && adv;

  // Effective width, clamped to [3, MaxWidth].
  logic [CntW-1:0] w_eff;
  always_comb begin
    if (grid_width_q < GridW'(3))                 w_eff = CntW'(3);
    else if (32'(grid_width_q) > MaxWidth)        w_eff = CntW'(MaxWidth);
    else                                          w_eff = CntW'(grid_width_q);
  end

  // Column and row counters.
  logic [ColW-1:0] col_q, col_d, col;
  logic [1:0]      rows_q, rows_d, rows;
  logic            last_col;
  always_comb begin
    col  = s_axis_tuser ? '0 : col_q;
    rows = s_axis_tuser ? 2'd0 : rows_q;
    last_col = (CntW'(col) + CntW'(1)) >= w_eff;
    col_d  = last_col ? '0 : col + ColW'(1);
    rows_d = (last_col && rows != 2'd2) ? rows + 2'd1 : rows;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      rows_q <= 2'd0;
    end else if (acc) begin
      col_q  <= col_d;
      rows_q <= rows_d;
    end
  end

  // Line buffer: two banks (even and odd column) so centre and right read at once.
  localparam int unsigned BankD = (MaxWidth + 1) / 2;
  localparam int unsigned BankW = (BankD > 1) ? $clog2(BankD) : 1;
  logic [HeightW-1:0] bank_e [BankD];
  logic [HeightW-1:0] bank_o [BankD];
  logic [ColW-1:0]    colr;
  logic [BankW-1:0]   ae, ao;
  logic [HeightW-1:0] rd_e_q, rd_o_q;
  always_comb begin
    colr = col + ColW'(1);
    // Centre col and right col+1 lie in opposite banks.
    ae = col[0] ? BankW'(colr >> 1) : BankW'(col >> 1);
    ao = BankW'(col >> 1);
  end
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_e_q <= bank_e[ae];
      rd_o_q <= bank_o[ao];
      if (col[0]) bank_o[BankW'(col >> 1)] <= s_axis_tdata;
      else        bank_e[BankW'(col >> 1)] <= s_axis_tdata;
    end
  end

  // Stage A: registered sample and control beside the buffer read.
  logic               va_q;
  logic               bord_a_q, odd_a_q;
  logic [HeightW-1:0] up_a_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (adv) va_q <= acc && (rows != 2'd0);
  end
  always_ff @(posedge clk_i) begin
    if (acc) begin
      bord_a_q <= (rows == 2'd1) || (col == '0) || last_col;
      odd_a_q  <= col[0];
      up_a_q   <= s_axis_tdata;
    end
  end

  // Stage B: differences times gain.
  logic [HeightW-1:0] ctr, rgt;
  logic signed [HeightW:0] du_raw, dr_raw;
  logic signed [DiffW-1:0] du_q, dr_q;
  assign ctr    = odd_a_q ? rd_o_q : rd_e_q;
  assign rgt    = odd_a_q ? rd_e_q : rd_o_q;
  assign du_raw = $signed({1'b0, up_a_q}) - $signed({1'b0, ctr});
  assign dr_raw = $signed({1'b0, rgt}) - $signed({1'b0, ctr});
  always_ff @(posedge clk_i) begin
    if (adv) begin
      du_q <= DiffW'(du_raw) * $signed({1'b0, gain_q});
      dr_q <= DiffW'(dr_raw) * $signed({1'b0, gain_q});
    end
  end

  // Control delay line covering stage B and the unit pipelines.
  vtx_ctl_t ctl_q [LatW+1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LatW; k++) ctl_q[k] <= '0;
    end else if (adv) begin
      ctl_q[0] <= '{vld: va_q, border: bord_a_q};
      for (int k = 1; k <= LatW; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  // Unit-vector pipelines for the normal and tangent.
  localparam logic signed [DiffW-1:0] Unit = DiffW'(65536);
  logic [CompW-1:0] nx, ny, nz, tx, ty, tz;
  hnt_unit3 u_norm (
    .clk_i, .rst_ni, .en_i(adv),
    .v0_i(du_q), .v1_i(-Unit), .v2_i(dr_q),
    .r0_o(nx), .r1_o(ny), .r2_o(nz)
  );
  hnt_unit3 u_tang (
    .clk_i, .rst_ni, .en_i(adv),
    .v0_i('0), .v1_i(dr_q), .v2_i(Unit),
    .r0_o(tx), .r1_o(ty), .r2_o(tz)
  );

  // Output register; the control entry lines up with the unit result registers.
  vtx_ctl_t oc;
  assign oc = ctl_q[LatW];
  logic unused_tx;
  assign unused_tx = ^tx;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= oc.vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tuser <= oc.border;
      m_axis_tdata <= oc.border ? '0 : {tz, ty, nz, ny, nx};
    end
  end

endmodule

// ----- sv/hnt_unit3.sv -----
// Pipelined unit-vector unit: normalizes a 3-vector of Q.16 integers to Q1.15.
// Depends on hnt_pkg. Stages: magnitude, normalize shift, squares, sum of squares,
// bit-serial square root unrolled as stages, division stages, saturation.
module hnt_unit3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic signed [hnt_pkg::DiffW-1:0] v0_i,
  input  logic signed [hnt_pkg::DiffW-1:0] v1_i,
  input  logic signed [hnt_pkg::DiffW-1:0] v2_i,
  output logic [hnt_pkg::CompW-1:0]     r0_o,
  output logic [hnt_pkg::CompW-1:0]     r1_o,
  output logic [hnt_pkg::CompW-1:0]     r2_o
);
  import hnt_pkg::*;

  localparam int unsigned MagW  = DiffW;
  localparam int unsigned NrmW  = 30;
  localparam int unsigned SqW   = 62;
  localparam int unsigned RootW = 31;
  localparam int unsigned RootSteps = 31;
  localparam int unsigned QW    = 16;
  localparam int unsigned DivSteps = QW;
  localparam int unsigned NumW  = NrmW + 17;
  localparam int unsigned DenW  = RootW + 1;

  // Stage 1: magnitude and sign.
  logic [MagW-1:0] m_q [3];
  logic [2:0]      neg1_q;
  logic [MagW-1:0] mx_q;
  logic [MagW-1:0] a0, a1, a2, mx;

  always_comb begin
    a0 = v0_i[DiffW-1] ? MagW'(-v0_i) : MagW'(v0_i);
    a1 = v1_i[DiffW-1] ? MagW'(-v1_i) : MagW'(v1_i);
    a2 = v2_i[DiffW-1] ? MagW'(-v2_i) : MagW'(v2_i);
    mx = a0;
    if (a1 > mx) mx = a1;
    if (a2 > mx) mx = a2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= a0;
      m_q[1] <= a1;
      m_q[2] <= a2;
      mx_q   <= mx;
      neg1_q <= {v2_i[DiffW-1], v1_i[DiffW-1], v0_i[DiffW-1]};
    end
  end

  // Stage 2: shift so the largest lies in [2^29, 2^30).
  logic [5:0]      lz;
  logic            left;
  logic [5:0]      sh;
  logic [NrmW-1:0] n_q [3];
  logic [2:0]      neg2_q;
  logic            zero2_q;
  logic [NrmW-1:0] nrm [3];

  always_comb begin
    lz = 6'd0;
    for (int b = 0; b < MagW; b++) begin
      if (mx_q[b]) lz = 6'(b);
    end
    left = (lz < 6'd29);
    sh   = left ? 6'd29 - lz : lz - 6'd29;
    for (int k = 0; k < 3; k++) begin
      nrm[k] = left ? NrmW'(m_q[k] << sh) : NrmW'(m_q[k] >> sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) n_q[k] <= nrm[k];
      neg2_q  <= neg1_q;
      zero2_q <= (mx_q == '0);
    end
  end

  // Stage 3: squares.
  logic [SqW-1:0]  sq_q [3];
  logic [NrmW-1:0] n3_q [3];
  logic [2:0]      neg3_q;
  logic            zero3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= SqW'(n_q[k]) * SqW'(n_q[k]);
        n3_q[k] <= n_q[k];
      end
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
    end
  end

  // Stage 4: sum of squares.
  logic [SqW+1:0]  s_q;
  logic [NrmW-1:0] n4_q [3];
  logic [2:0]      neg4_q;
  logic            zero4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= (SqW+2)'(sq_q[0]) + (SqW+2)'(sq_q[1]) + (SqW+2)'(sq_q[2]);
      for (int k = 0; k < 3; k++) n4_q[k] <= n3_q[k];
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
    end
  end

  // Square root: one result bit per stage (restoring method).
  localparam int unsigned RemW = SqW + 4;
  logic [RemW-1:0]  rr_q   [RootSteps+1];
  logic [RemW-1:0]  rv_q   [RootSteps+1];
  logic [RootW-1:0] rt_q   [RootSteps+1];
  logic [NrmW-1:0]  rn_q   [RootSteps+1][3];
  logic [2:0]       rneg_q [RootSteps+1];
  logic             rz_q   [RootSteps+1];

  always_comb begin
    rr_q[0] = '0;
    rv_q[0] = RemW'(s_q);
    rt_q[0] = '0;
    for (int k = 0; k < 3; k++) rn_q[0][k] = n4_q[k];
    rneg_q[0] = neg4_q;
    rz_q[0]   = zero4_q;
  end

  for (genvar g = 0; g < RootSteps; g++) begin : g_root
    logic [RemW-1:0]  rem_n;
    logic [RemW-1:0]  trial;
    always_comb begin
      rem_n = (rr_q[g] << 2) |
              RemW'(rv_q[g][2*(RootSteps-1-g) +: 2]);
      trial = (RemW'(rt_q[g]) << 2) | RemW'(1);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_n >= trial) begin
          rr_q[g+1] <= rem_n - trial;
          rt_q[g+1] <= RootW'({rt_q[g], 1'b1});
        end else begin
          rr_q[g+1] <= rem_n;
          rt_q[g+1] <= RootW'({rt_q[g], 1'b0});
        end
        rv_q[g+1] <= rv_q[g];
        for (int k = 0; k < 3; k++) rn_q[g+1][k] <= rn_q[g][k];
        rneg_q[g+1] <= rneg_q[g];
        rz_q[g+1]   <= rz_q[g];
      end
    end
  end

  // Division: q = (mag*65536 + L) / (2L), one quotient bit per stage, three lanes.
  localparam int unsigned DRemW = DenW + 1;
  logic [NumW-1:0]  dnum_q [DivSteps+1][3];
  logic [DRemW-1:0] drem_q [DivSteps+1][3];
  logic [QW-1:0]    dq_q   [DivSteps+1][3];
  logic [DenW-1:0]  dden_q [DivSteps+1];
  logic [2:0]       dneg_q [DivSteps+1];
  logic             dz_q   [DivSteps+1];
  logic [NumW-1:0]  num0 [3];
  logic [DRemW-1:0] pre0 [3];
  logic [DenW-1:0]  den0;

  // The quotient is below 2^16, so the top bits of the numerator seed the remainder.
  always_comb begin
    den0 = {rt_q[RootSteps], 1'b0};
    for (int k = 0; k < 3; k++) begin
      num0[k] = (NumW'(rn_q[RootSteps][k]) << 16) + NumW'(rt_q[RootSteps]);
      pre0[k] = DRemW'(num0[k] >> QW);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        dnum_q[0][k] <= num0[k];
        drem_q[0][k] <= pre0[k];
        dq_q[0][k]   <= '0;
      end
      dden_q[0] <= den0;
      dneg_q[0] <= rneg_q[RootSteps];
      dz_q[0]   <= rz_q[RootSteps];
    end
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    logic [DRemW:0] rem_n [3];
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        rem_n[k] = {drem_q[g][k], dnum_q[g][k][QW-1-g]};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < 3; k++) begin
          if (rem_n[k] >= (DRemW+1)'(dden_q[g])) begin
            drem_q[g+1][k] <= DRemW'(rem_n[k] - (DRemW+1)'(dden_q[g]));
            dq_q[g+1][k]   <= {dq_q[g][k][QW-2:0], 1'b1};
          end else begin
            drem_q[g+1][k] <= DRemW'(rem_n[k]);
            dq_q[g+1][k]   <= {dq_q[g][k][QW-2:0], 1'b0};
          end
          dnum_q[g+1][k] <= dnum_q[g][k];
        end
        dden_q[g+1] <= dden_q[g];
        dneg_q[g+1] <= dneg_q[g];
        dz_q[g+1]   <= dz_q[g];
      end
    end
  end

  // Saturate and apply sign.
  logic [CompW-1:0] res [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [QW-1:0] c;
      c = (dq_q[DivSteps][k] > 16'd32767) ? 16'd32767 : dq_q[DivSteps][k];
      if (dz_q[DivSteps])          res[k] = '0;
      else if (dneg_q[DivSteps][k]) res[k] = CompW'(-c);
      else                         res[k] = c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_o <= '0;
      r1_o <= '0;
      r2_o <= '0;
    end else if (en_i) begin
      r0_o <= res[0];
      r1_o <= res[1];
      r2_o <= res[2];
    end
  end

endmodule
